/* hdl/elob_pkg.sv */
`timescale 1ns / 1ps
// Package for the enveloped LED overlay blend: widths, codes and the
// structs passed between pipeline stages. Depends on nothing.
package elob_pkg;

   localparam int TIME_BITS        = 32;
   localparam int WEIGHT_FRAC_BITS = 16;
   localparam int WEIGHT_BITS      = WEIGHT_FRAC_BITS + 1;
   localparam int CHAN_BITS        = 8;
   localparam int PROD_BITS        = CHAN_BITS + WEIGHT_BITS;
   localparam int CSR_INDEX_BITS   = 3;
   localparam int CSR_DATA_BITS    = TIME_BITS;

   localparam logic [WEIGHT_BITS-1:0] WEIGHT_ONE =
      {1'b1, {WEIGHT_FRAC_BITS{1'b0}}};
   localparam logic [WEIGHT_BITS-1:0] WEIGHT_THRESH =
      WEIGHT_BITS'((64'd1 << WEIGHT_FRAC_BITS) / 64'd10000);
   localparam logic [CHAN_BITS-1:0] CHAN_MAX = {CHAN_BITS{1'b1}};

   localparam logic [CSR_INDEX_BITS-1:0] CSR_START_TIME     = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TOTAL_DURATION = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ATTACK_TIME    = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FADE_TIME      = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_HELD           = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MIX_MODE       = 3'd5;

   localparam logic [1:0] MIX_BLEND   = 2'd0;
   localparam logic [1:0] MIX_REPLACE = 2'd1;
   localparam logic [1:0] MIX_ADD     = 2'd2;

   typedef enum logic [1:0] {
      WK_ZERO,
      WK_ONE,
      WK_DIV
   } wkind_type;

   typedef struct packed {
      logic [TIME_BITS-1:0] start_time;
      logic [TIME_BITS-1:0] total_duration;
      logic [TIME_BITS-1:0] attack_time;
      logic [TIME_BITS-1:0] fade_time;
      logic                 held;
      logic [1:0]           mix_mode;
   } cfg_type;

   typedef struct packed {
      logic [CHAN_BITS-1:0] base_red;
      logic [CHAN_BITS-1:0] base_green;
      logic [CHAN_BITS-1:0] base_blue;
      logic [CHAN_BITS-1:0] over_red;
      logic [CHAN_BITS-1:0] over_green;
      logic [CHAN_BITS-1:0] over_blue;
   } pixel_type;

   typedef struct packed {
      logic                        valid;
      wkind_type                   kind;
      logic [TIME_BITS-1:0]        rem;
      logic [TIME_BITS-1:0]        den;
      logic [WEIGHT_FRAC_BITS-1:0] quo;
      pixel_type                   pix;
   } stage_type;

endpackage

/* hdl/elob_env.sv */
`timescale 1ns / 1ps
// Envelope front end: two register stages that classify the time against
// the configured envelope. Depends on elob_pkg.
module elob_env (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  logic [elob_pkg::TIME_BITS-1:0] now_time,
   input  elob_pkg::pixel_type           in_pix,
   input  elob_pkg::cfg_type             cfg,
   output elob_pkg::stage_type           out_stage
);
   import elob_pkg::*;

   logic                 s1_valid_ff;
   logic                 s1_before_ff;
   logic [TIME_BITS-1:0] s1_delta_ff;
   logic                 s1_held_ff;
   logic [TIME_BITS-1:0] s1_dur_ff;
   logic [TIME_BITS-1:0] s1_attack_ff;
   logic                 s1_attack_nz_ff;
   logic [TIME_BITS-1:0] s1_fade_ff;
   logic                 s1_fade_ok_ff;
   logic [TIME_BITS-1:0] s1_dmf_ff;
   pixel_type            s1_pix_ff;

   stage_type            s2_in;
   stage_type            s2_ff;
   logic [TIME_BITS-1:0] dur_minus_delta;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= in_valid;
      end
      s1_before_ff    <= now_time < cfg.start_time;
      s1_delta_ff     <= now_time - cfg.start_time;
      s1_held_ff      <= cfg.held;
      s1_dur_ff       <= cfg.total_duration;
      s1_attack_ff    <= cfg.attack_time;
      s1_attack_nz_ff <= cfg.attack_time != '0;
      s1_fade_ff      <= cfg.fade_time;
      s1_fade_ok_ff   <= (cfg.fade_time != '0) && (cfg.total_duration > cfg.fade_time);
      s1_dmf_ff       <= cfg.total_duration - cfg.fade_time;
      s1_pix_ff       <= in_pix;
   end

   assign dur_minus_delta = s1_dur_ff - s1_delta_ff;

   always_comb begin
      s2_in       = '0;
      s2_in.valid = s1_valid_ff;
      s2_in.pix   = s1_pix_ff;
      s2_in.kind  = WK_ONE;
      if (s1_before_ff) begin
         s2_in.kind = WK_ZERO;
      end else if (s1_held_ff) begin
         s2_in.kind = WK_ONE;
      end else if (s1_delta_ff >= s1_dur_ff) begin
         s2_in.kind = WK_ZERO;
      end else if (s1_attack_nz_ff && (s1_delta_ff < s1_attack_ff)) begin
         s2_in.kind = WK_DIV;
         s2_in.rem  = s1_delta_ff;
         s2_in.den  = s1_attack_ff;
      end else if (s1_fade_ok_ff && (s1_delta_ff >= s1_dmf_ff)) begin
         if (s1_delta_ff == s1_dmf_ff) begin
            s2_in.kind = WK_ONE;
         end else begin
            s2_in.kind = WK_DIV;
            s2_in.rem  = dur_minus_delta;
            s2_in.den  = s1_fade_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_ff.valid <= 1'b0;
      end else begin
         s2_ff.valid <= s2_in.valid;
      end
      s2_ff.kind <= s2_in.kind;
      s2_ff.rem  <= s2_in.rem;
      s2_ff.den  <= s2_in.den;
      s2_ff.quo  <= s2_in.quo;
      s2_ff.pix  <= s2_in.pix;
   end

   assign out_stage = s2_ff;

endmodule

/* hdl/elob_div_step.sv */
`timescale 1ns / 1ps
// One restoring division step of the envelope ramp, registered: one
// quotient bit per stage. Depends on elob_pkg.
module elob_div_step (
   input  logic                clock,
   input  logic                reset,
   input  elob_pkg::stage_type in_stage,
   output elob_pkg::stage_type out_stage
);
   import elob_pkg::*;

   logic [TIME_BITS:0]   shifted;
   logic [TIME_BITS:0]   diff;
   logic                 fits;
   stage_type            step_ff;

   assign shifted = {in_stage.rem, 1'b0};
   assign diff    = shifted - {1'b0, in_stage.den};
   assign fits    = shifted >= {1'b0, in_stage.den};

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff.valid <= 1'b0;
      end else begin
         step_ff.valid <= in_stage.valid;
      end
      step_ff.kind <= in_stage.kind;
      step_ff.den  <= in_stage.den;
      step_ff.pix  <= in_stage.pix;
      step_ff.rem  <= fits ? diff[TIME_BITS-1:0] : shifted[TIME_BITS-1:0];
      step_ff.quo  <= {in_stage.quo[WEIGHT_FRAC_BITS-2:0], fits};
   end

   assign out_stage = step_ff;

endmodule

/* hdl/elob_mix.sv */
`timescale 1ns / 1ps
// Pixel mixer: weight decode and products in one stage, then sums,
// saturation and the output register. Depends on elob_pkg.
module elob_mix (
   input  logic                          clock,
   input  logic                          reset,
   input  elob_pkg::stage_type           in_stage,
   input  logic [1:0]                    mix_mode,
   output logic                          out_strobe,
   output logic [elob_pkg::CHAN_BITS-1:0] out_red,
   output logic [elob_pkg::CHAN_BITS-1:0] out_green,
   output logic [elob_pkg::CHAN_BITS-1:0] out_blue,
   output logic [elob_pkg::WEIGHT_BITS-1:0] out_weight,
   output logic                          out_applied
);
   import elob_pkg::*;

   logic [WEIGHT_BITS-1:0] weight_in;
   logic [WEIGHT_BITS-1:0] inv_weight;
   logic                   over_lit;
   logic                   applied_in;
   logic [CHAN_BITS-1:0]   base_ch[3];
   logic [CHAN_BITS-1:0]   over_ch[3];

   logic                   m1_valid_ff;
   logic [WEIGHT_BITS-1:0] m1_weight_ff;
   logic                   m1_applied_ff;
   logic                   m1_add_ff;
   logic [CHAN_BITS-1:0]   m1_base_ff[3];
   logic [PROD_BITS-1:0]   m1_pover_ff[3];
   logic [PROD_BITS-1:0]   m1_pbase_ff[3];

   logic [PROD_BITS:0]     cross_sum[3];
   logic [CHAN_BITS:0]     add_sum[3];
   logic [CHAN_BITS-1:0]   res_in[3];

   logic                   strobe_ff;
   logic [CHAN_BITS-1:0]   res_ff[3];
   logic [WEIGHT_BITS-1:0] weight_ff;
   logic                   applied_ff;

   always_comb begin
      case (in_stage.kind)
         WK_ZERO: weight_in = '0;
         WK_DIV:  weight_in = {1'b0, in_stage.quo};
         default: weight_in = WEIGHT_ONE;
      endcase
   end

   assign inv_weight = WEIGHT_ONE - weight_in;
   assign base_ch[0] = in_stage.pix.base_red;
   assign base_ch[1] = in_stage.pix.base_green;
   assign base_ch[2] = in_stage.pix.base_blue;
   assign over_ch[0] = in_stage.pix.over_red;
   assign over_ch[1] = in_stage.pix.over_green;
   assign over_ch[2] = in_stage.pix.over_blue;
   assign over_lit   = (over_ch[0] | over_ch[1] | over_ch[2]) != '0;
   assign applied_in = (weight_in > WEIGHT_THRESH) &&
                       ((mix_mode == MIX_REPLACE) || (mix_mode == MIX_ADD) || over_lit);

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_valid_ff <= 1'b0;
      end else begin
         m1_valid_ff <= in_stage.valid;
      end
      m1_weight_ff  <= weight_in;
      m1_applied_ff <= applied_in;
      m1_add_ff     <= mix_mode == MIX_ADD;
      for (int c = 0; c < 3; c++) begin
         m1_base_ff[c]  <= base_ch[c];
         m1_pover_ff[c] <= PROD_BITS'(over_ch[c]) * PROD_BITS'(weight_in);
         m1_pbase_ff[c] <= PROD_BITS'(base_ch[c]) * PROD_BITS'(inv_weight);
      end
   end

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         cross_sum[c] = {1'b0, m1_pover_ff[c]} + {1'b0, m1_pbase_ff[c]};
         add_sum[c]   = {1'b0, m1_base_ff[c]} +
                        {1'b0, m1_pover_ff[c][WEIGHT_FRAC_BITS +: CHAN_BITS]};
         if (!m1_applied_ff) begin
            res_in[c] = m1_base_ff[c];
         end else if (m1_add_ff) begin
            res_in[c] = add_sum[c][CHAN_BITS] ? CHAN_MAX : add_sum[c][CHAN_BITS-1:0];
         end else begin
            res_in[c] = cross_sum[c][WEIGHT_FRAC_BITS +: CHAN_BITS];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= m1_valid_ff;
      end
      weight_ff  <= m1_weight_ff;
      applied_ff <= m1_applied_ff;
      for (int c = 0; c < 3; c++) begin
         res_ff[c] <= res_in[c];
      end
   end

   assign out_strobe  = strobe_ff;
   assign out_red     = res_ff[0];
   assign out_green   = res_ff[1];
   assign out_blue    = res_ff[2];
   assign out_weight  = weight_ff;
   assign out_applied = applied_ff;

   weight_bounded: assert property (@(posedge clock) disable iff (reset)
      strobe_ff |-> (weight_ff <= WEIGHT_ONE))
      else $error("mix weight above one");

   applied_needs_weight: assert property (@(posedge clock) disable iff (reset)
      (strobe_ff && applied_ff) |-> (weight_ff > WEIGHT_THRESH))
      else $error("pixel applied with a weak weight");

   bypass_keeps_base: assert property (@(posedge clock) disable iff (reset)
      (m1_valid_ff && !m1_applied_ff) |=>
         ((res_ff[0] == $past(m1_base_ff[0])) && (res_ff[1] == $past(m1_base_ff[1])) &&
          (res_ff[2] == $past(m1_base_ff[2]))))
      else $error("bypassed pixel differs from base");

endmodule

/* hdl/enveloped_led_overlay_blend.sv */
`timescale 1ns / 1ps
// Top level of the enveloped LED overlay blend: register file, envelope
// front end, division pipeline and mixer. Depends on elob_pkg and all elob_ modules.
//
//   channel   ports                               handshake
//   request   start, busy, req_*                  beat taken when start && !busy
//   response  rsp_strobe, rsp_*                   one-cycle strobe, no back-pressure
//   config    csr_write_enable, csr_index, csr_*  write on enable, no wait
//
// One pixel is taken every cycle while busy is low; each result passes through
// the two envelope stages, one stage per quotient bit of the 16-bit ramp
// division, and the two mixer stages before its response strobe.
// Reset clears the config and all valid bits; busy is high during reset.
// Nothing stalls: the response side takes every beat as it comes.
module enveloped_led_overlay_blend (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [elob_pkg::TIME_BITS-1:0]       req_now_time,
   input  logic [elob_pkg::CHAN_BITS-1:0]       req_base_red,
   input  logic [elob_pkg::CHAN_BITS-1:0]       req_base_green,
   input  logic [elob_pkg::CHAN_BITS-1:0]       req_base_blue,
   input  logic [elob_pkg::CHAN_BITS-1:0]       req_over_red,
   input  logic [elob_pkg::CHAN_BITS-1:0]       req_over_green,
   input  logic [elob_pkg::CHAN_BITS-1:0]       req_over_blue,
   output logic                                 rsp_strobe,
   output logic [elob_pkg::CHAN_BITS-1:0]       rsp_out_red,
   output logic [elob_pkg::CHAN_BITS-1:0]       rsp_out_green,
   output logic [elob_pkg::CHAN_BITS-1:0]       rsp_out_blue,
   output logic [elob_pkg::WEIGHT_BITS-1:0]     rsp_mix_weight,
   output logic                                 rsp_applied,
   input  logic                                 csr_write_enable,
   input  logic [elob_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [elob_pkg::CSR_DATA_BITS-1:0]   csr_write_data
);
   import elob_pkg::*;

   cfg_type   cfg_ff;
   pixel_type req_pix;
   logic      accept;
   stage_type div_chain[WEIGHT_FRAC_BITS+1];

   assign busy   = reset;
   assign accept = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_START_TIME:     cfg_ff.start_time     <= csr_write_data[TIME_BITS-1:0];
            CSR_TOTAL_DURATION: cfg_ff.total_duration <= csr_write_data[TIME_BITS-1:0];
            CSR_ATTACK_TIME:    cfg_ff.attack_time    <= csr_write_data[TIME_BITS-1:0];
            CSR_FADE_TIME:      cfg_ff.fade_time      <= csr_write_data[TIME_BITS-1:0];
            CSR_HELD:           cfg_ff.held           <= csr_write_data[0];
            CSR_MIX_MODE:       cfg_ff.mix_mode       <= csr_write_data[1:0];
            default: ;
         endcase
      end
   end

   assign req_pix.base_red   = req_base_red;
   assign req_pix.base_green = req_base_green;
   assign req_pix.base_blue  = req_base_blue;
   assign req_pix.over_red   = req_over_red;
   assign req_pix.over_green = req_over_green;
   assign req_pix.over_blue  = req_over_blue;

   elob_env u_env (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .now_time  (req_now_time),
      .in_pix    (req_pix),
      .cfg       (cfg_ff),
      .out_stage (div_chain[0])
   );

   for (genvar i = 0; i < WEIGHT_FRAC_BITS; i++) begin : g_div
      elob_div_step u_step (
         .clock     (clock),
         .reset     (reset),
         .in_stage  (div_chain[i]),
         .out_stage (div_chain[i+1])
      );
   end

   elob_mix u_mix (
      .clock       (clock),
      .reset       (reset),
      .in_stage    (div_chain[WEIGHT_FRAC_BITS]),
      .mix_mode    (cfg_ff.mix_mode),
      .out_strobe  (rsp_strobe),
      .out_red     (rsp_out_red),
      .out_green   (rsp_out_green),
      .out_blue    (rsp_out_blue),
      .out_weight  (rsp_mix_weight),
      .out_applied (rsp_applied)
   );

endmodule

/* tb/sv/enveloped_led_overlay_blend_tb.sv */
`timescale 1ns / 1ps
// Testbench for enveloped_led_overlay_blend: directed and random pixel beats
// checked against an envelope and mixing predictor. Depends on elob_pkg and the RTL.
module enveloped_led_overlay_blend_tb;
   import elob_pkg::*;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE_HI = 3'd7;
   localparam logic [1:0] MIX_SPARE = 2'd3;
   localparam int RANDOM_PIXELS = 1900;

   typedef struct packed {
      logic [CHAN_BITS-1:0]   red;
      logic [CHAN_BITS-1:0]   green;
      logic [CHAN_BITS-1:0]   blue;
      logic [WEIGHT_BITS-1:0] weight;
      logic                   applied;
   } blend_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [TIME_BITS-1:0] req_now_time = '0;
   logic [CHAN_BITS-1:0] req_base_red = '0;
   logic [CHAN_BITS-1:0] req_base_green = '0;
   logic [CHAN_BITS-1:0] req_base_blue = '0;
   logic [CHAN_BITS-1:0] req_over_red = '0;
   logic [CHAN_BITS-1:0] req_over_green = '0;
   logic [CHAN_BITS-1:0] req_over_blue = '0;
   logic rsp_strobe;
   logic [CHAN_BITS-1:0] rsp_out_red;
   logic [CHAN_BITS-1:0] rsp_out_green;
   logic [CHAN_BITS-1:0] rsp_out_blue;
   logic [WEIGHT_BITS-1:0] rsp_mix_weight;
   logic rsp_applied;
   logic csr_write_enable = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0] csr_write_data = '0;

   cfg_type active_envelope = '0;
   blend_result_type expected_pixels[$];
   int unsigned mismatch_count = 0;
   bit sender_steady = 1'b0;

   enveloped_led_overlay_blend uut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_now_time     (req_now_time),
      .req_base_red     (req_base_red),
      .req_base_green   (req_base_green),
      .req_base_blue    (req_base_blue),
      .req_over_red     (req_over_red),
      .req_over_green   (req_over_green),
      .req_over_blue    (req_over_blue),
      .rsp_strobe       (rsp_strobe),
      .rsp_out_red      (rsp_out_red),
      .rsp_out_green    (rsp_out_green),
      .rsp_out_blue     (rsp_out_blue),
      .rsp_mix_weight   (rsp_mix_weight),
      .rsp_applied      (rsp_applied),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   initial begin
      #500_000;
      $display("[enveloped_led_overlay_blend] ERROR");
      $finish;
   end

   function automatic logic [WEIGHT_BITS-1:0] ramp_fraction(logic [63:0] part,
                                                            logic [63:0] whole);
      logic [63:0] quotient;
      if (part >= whole) return WEIGHT_ONE;
      quotient = (part << WEIGHT_FRAC_BITS) / whole;
      return quotient[WEIGHT_BITS-1:0];
   endfunction

   function automatic logic [WEIGHT_BITS-1:0] envelope_weight(cfg_type c,
                                                              logic [TIME_BITS-1:0] now);
      logic [63:0] delta;
      logic [63:0] duration;
      logic [63:0] attack;
      logic [63:0] fade;
      duration = 64'(c.total_duration);
      attack = 64'(c.attack_time);
      fade = 64'(c.fade_time);
      if (now < c.start_time) return '0;
      if (c.held) return WEIGHT_ONE;
      delta = 64'(now) - 64'(c.start_time);
      if (delta >= duration) return '0;
      if (attack != 0 && delta < attack) return ramp_fraction(delta, attack);
      if (fade != 0 && duration > fade && delta >= duration - fade) begin
         return ramp_fraction(duration - delta, fade);
      end
      return WEIGHT_ONE;
   endfunction

   function automatic logic [CHAN_BITS-1:0] crossfade(logic [CHAN_BITS-1:0] base,
                                                      logic [CHAN_BITS-1:0] over,
                                                      logic [WEIGHT_BITS-1:0] w);
      logic [63:0] mix;
      mix = (64'(over) * 64'(w) + 64'(base) * (64'(WEIGHT_ONE) - 64'(w)))
            >> WEIGHT_FRAC_BITS;
      return mix[CHAN_BITS-1:0];
   endfunction

   function automatic logic [CHAN_BITS-1:0] add_clipped(logic [CHAN_BITS-1:0] base,
                                                        logic [CHAN_BITS-1:0] over,
                                                        logic [WEIGHT_BITS-1:0] w);
      logic [63:0] sum;
      sum = 64'(base) + ((64'(over) * 64'(w)) >> WEIGHT_FRAC_BITS);
      if (sum > 64'(CHAN_MAX)) return CHAN_MAX;
      return sum[CHAN_BITS-1:0];
   endfunction

   function automatic blend_result_type blend_pixel(cfg_type c, logic [TIME_BITS-1:0] now,
                                                    pixel_type p);
      blend_result_type r;
      logic [WEIGHT_BITS-1:0] w;
      logic over_lit;
      w = envelope_weight(c, now);
      over_lit = (p.over_red | p.over_green | p.over_blue) != '0;
      r.red = p.base_red;
      r.green = p.base_green;
      r.blue = p.base_blue;
      r.weight = w;
      r.applied = 1'b0;
      if (w > WEIGHT_THRESH) begin
         if (c.mix_mode == MIX_ADD) begin
            r.red = add_clipped(p.base_red, p.over_red, w);
            r.green = add_clipped(p.base_green, p.over_green, w);
            r.blue = add_clipped(p.base_blue, p.over_blue, w);
            r.applied = 1'b1;
         end else if (c.mix_mode == MIX_REPLACE || over_lit) begin
            r.red = crossfade(p.base_red, p.over_red, w);
            r.green = crossfade(p.base_green, p.over_green, w);
            r.blue = crossfade(p.base_blue, p.over_blue, w);
            r.applied = 1'b1;
         end
      end
      return r;
   endfunction

   function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $error("%s expected %0d got %0d", name, want, got);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin
      blend_result_type due;
      if (rsp_strobe === 1'b1) begin
         if (expected_pixels.size() == 0) begin
            $error("result beat with no pixel outstanding");
            mismatch_count++;
         end else begin
            due = expected_pixels.pop_front();
            compare_field("out_red", 32'(due.red), 32'(rsp_out_red));
            compare_field("out_green", 32'(due.green), 32'(rsp_out_green));
            compare_field("out_blue", 32'(due.blue), 32'(rsp_out_blue));
            compare_field("mix_weight", 32'(due.weight), 32'(rsp_mix_weight));
            compare_field("applied", 32'(due.applied), 32'(rsp_applied));
         end
      end
   end

   task automatic send_pixel(logic [TIME_BITS-1:0] now, pixel_type p);
      int unsigned gap;
      blend_result_type predicted;
      gap = sender_steady ? 0 : $urandom_range(0, 13);
      if (gap != 0) begin
         @(negedge clock);
         start <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      start <= 1'b1;
      req_now_time <= now;
      req_base_red <= p.base_red;
      req_base_green <= p.base_green;
      req_base_blue <= p.base_blue;
      req_over_red <= p.over_red;
      req_over_green <= p.over_green;
      req_over_blue <= p.over_blue;
      do @(posedge clock); while (busy !== 1'b0);
      predicted = blend_pixel(active_envelope, now, p);
      expected_pixels = {expected_pixels, predicted};
   endtask

   task automatic settle_outputs();
      @(negedge clock);
      start <= 1'b0;
      while (expected_pixels.size() != 0) @(posedge clock);
   endtask

   task automatic write_register(logic [CSR_INDEX_BITS-1:0] index,
                                 logic [CSR_DATA_BITS-1:0] data);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= index;
      csr_write_data <= data;
   endtask

   task automatic apply_config(cfg_type c);
      logic [CSR_DATA_BITS-1:0] flags;
      write_register(CSR_START_TIME, c.start_time);
      write_register(CSR_TOTAL_DURATION, c.total_duration);
      write_register(CSR_ATTACK_TIME, c.attack_time);
      write_register(CSR_FADE_TIME, c.fade_time);
      flags = $urandom;
      flags[0] = c.held;
      write_register(CSR_HELD, flags);
      flags = $urandom;
      flags[1:0] = c.mix_mode;
      write_register(CSR_MIX_MODE, flags);
      write_register($urandom_range(0, 1) ? CSR_SPARE_LO : CSR_SPARE_HI, $urandom);
      @(negedge clock);
      csr_write_enable <= 1'b0;
      active_envelope = c;
   endtask

   function automatic cfg_type make_envelope(logic [31:0] start_time, logic [31:0] duration,
                                             logic [31:0] attack, logic [31:0] fade,
                                             logic held, logic [1:0] mode);
      cfg_type c;
      c.start_time = start_time;
      c.total_duration = duration;
      c.attack_time = attack;
      c.fade_time = fade;
      c.held = held;
      c.mix_mode = mode;
      return c;
   endfunction

   function automatic logic [31:0] draw_span();
      case ($urandom_range(0, 7))
         0: return 32'd0;
         1, 2, 3: return $urandom_range(1, 64);
         4, 5: return $urandom_range(1, 5000);
         6: return $urandom_range(1, 1 << 20);
         default: return $urandom;
      endcase
   endfunction

   function automatic cfg_type draw_envelope();
      cfg_type c;
      c.start_time = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 100000);
      c.total_duration = draw_span();
      if ($urandom_range(0, 3) == 0) c.attack_time = '0;
      else if ($urandom_range(0, 4) == 0) c.attack_time = draw_span();
      else c.attack_time = $urandom_range(0, c.total_duration);
      if ($urandom_range(0, 3) == 0) c.fade_time = '0;
      else if ($urandom_range(0, 4) == 0) c.fade_time = draw_span();
      else c.fade_time = $urandom_range(0, c.total_duration);
      c.held = ($urandom_range(0, 7) == 0);
      case ($urandom_range(0, 6))
         0, 1: c.mix_mode = MIX_BLEND;
         2, 3: c.mix_mode = MIX_REPLACE;
         4, 5: c.mix_mode = MIX_ADD;
         default: c.mix_mode = MIX_SPARE;
      endcase
      return c;
   endfunction

   function automatic logic [TIME_BITS-1:0] draw_time(cfg_type c);
      logic [63:0] span;
      logic [63:0] anchor;
      case ($urandom_range(0, 9))
         0: return $urandom;
         1: return c.start_time - $urandom_range(1, 16);
         2, 3: begin
            case ($urandom_range(0, 2))
               0: anchor = 64'(c.attack_time);
               1: anchor = 64'(c.total_duration) - 64'(c.fade_time);
               default: anchor = 64'(c.total_duration);
            endcase
            span = 64'(c.start_time) + anchor + 64'($urandom_range(0, 4)) - 64'd2;
            return span[TIME_BITS-1:0];
         end
         default: begin
            span = 64'(c.total_duration) + 64'(c.total_duration / 8) + 64'd2;
            if (span > 64'hFFFF_FFFF) span = 64'hFFFF_FFFF;
            return c.start_time + $urandom_range(0, span[31:0]);
         end
      endcase
   endfunction

   function automatic pixel_type draw_pixel();
      pixel_type p;
      p = 48'({$urandom, $urandom});
      if ($urandom_range(0, 5) == 0) {p.over_red, p.over_green, p.over_blue} = '0;
      case ($urandom_range(0, 9))
         0: {p.base_red, p.base_green, p.base_blue} = '1;
         1: {p.over_red, p.over_green, p.over_blue} = '1;
         2: {p.base_red, p.base_green, p.base_blue} = '0;
         default: ;
      endcase
      return p;
   endfunction

   task automatic test_reset_defaults();
      sender_steady = 1'b1;
      send_pixel(32'd0, pixel_type'{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF});
      send_pixel(32'hFFFF_FFFF, pixel_type'{8'h00, 8'h80, 8'h01, 8'h7F, 8'h40, 8'hFE});
   endtask

   task automatic test_envelope_ramps();
      settle_outputs();
      apply_config(make_envelope(32'd1000, 32'd100000, 32'd2000, 32'd10000, 1'b0,
                                 MIX_REPLACE));
      sender_steady = 1'b0;
      send_pixel(32'd999, pixel_type'{8'd10, 8'd20, 8'd30, 8'd200, 8'd100, 8'd50});
      send_pixel(32'd1000, pixel_type'{8'd10, 8'd20, 8'd30, 8'd200, 8'd100, 8'd50});
      send_pixel(32'd1001, pixel_type'{8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF});
      send_pixel(32'd2000, pixel_type'{8'hFF, 8'h00, 8'h80, 8'h00, 8'hFF, 8'h7F});
      send_pixel(32'd3000, pixel_type'{8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00});
      send_pixel(32'd91000, pixel_type'{8'd1, 8'd2, 8'd3, 8'd250, 8'd251, 8'd252});
      send_pixel(32'd100999, pixel_type'{8'd90, 8'd91, 8'd92, 8'hFF, 8'hFF, 8'hFF});
      send_pixel(32'd100998, pixel_type'{8'd90, 8'd91, 8'd92, 8'hFF, 8'hFF, 8'hFF});
      send_pixel(32'd101000, pixel_type'{8'd5, 8'd6, 8'd7, 8'hFF, 8'hFF, 8'hFF});
      send_pixel(32'hFFFF_FFFF, pixel_type'{8'd5, 8'd6, 8'd7, 8'hFF, 8'hFF, 8'hFF});
   endtask

   task automatic test_mix_modes();
      settle_outputs();
      apply_config(make_envelope(32'd1000, 32'd100000, 32'd2000, 32'd10000, 1'b0, MIX_ADD));
      sender_steady = 1'b1;
      send_pixel(32'd50000, pixel_type'{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF});
      send_pixel(32'd2000, pixel_type'{8'd200, 8'd100, 8'd0, 8'hFF, 8'hFF, 8'hFF});
      send_pixel(32'd50000, pixel_type'{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00});
      settle_outputs();
      apply_config(make_envelope(32'd1000, 32'd100000, 32'd2000, 32'd10000, 1'b0, MIX_BLEND));
      send_pixel(32'd50000, pixel_type'{8'd40, 8'd50, 8'd60, 8'h00, 8'h00, 8'h00});
      send_pixel(32'd2000, pixel_type'{8'd40, 8'd50, 8'd60, 8'h00, 8'h00, 8'h01});
      settle_outputs();
      apply_config(make_envelope(32'd1000, 32'd100000, 32'd2000, 32'd10000, 1'b0, MIX_SPARE));
      send_pixel(32'd50000, pixel_type'{8'd40, 8'd50, 8'd60, 8'h00, 8'h00, 8'h00});
      send_pixel(32'd1500, pixel_type'{8'd40, 8'd50, 8'd60, 8'h80, 8'h00, 8'h00});
   endtask

   task automatic test_held_and_limits();
      settle_outputs();
      apply_config(make_envelope(32'd5, 32'd0, 32'd0, 32'd0, 1'b1, MIX_REPLACE));
      sender_steady = 1'b0;
      send_pixel(32'd4, pixel_type'{8'd11, 8'd22, 8'd33, 8'd44, 8'd55, 8'd66});
      send_pixel(32'hFFFF_FFFF, pixel_type'{8'd11, 8'd22, 8'd33, 8'd44, 8'd55, 8'd66});
      settle_outputs();
      apply_config(make_envelope(32'd0, 32'd100, 32'd0, 32'd100, 1'b0, MIX_ADD));
      send_pixel(32'd99, pixel_type'{8'd100, 8'd100, 8'd100, 8'd100, 8'd100, 8'd100});
      send_pixel(32'd100, pixel_type'{8'd100, 8'd100, 8'd100, 8'd100, 8'd100, 8'd100});
      settle_outputs();
      apply_config(make_envelope(32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 1'b0,
                                 MIX_REPLACE));
      send_pixel(32'hFFFF_FFFE, pixel_type'{8'h00, 8'hFF, 8'h55, 8'hFF, 8'h00, 8'hAA});
   endtask

   task automatic test_random_overlays();
      int unsigned sent;
      int unsigned burst;
      sent = 0;
      while (sent < RANDOM_PIXELS) begin
         settle_outputs();
         apply_config(draw_envelope());
         sender_steady = ($urandom_range(0, 3) == 0);
         burst = $urandom_range(10, 80);
         repeat (burst) begin
            if ($urandom_range(0, 99) == 0) settle_outputs();
            send_pixel(draw_time(active_envelope), draw_pixel());
            sent++;
         end
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_envelope_ramps();
      test_mix_modes();
      test_held_and_limits();
      test_random_overlays();
      settle_outputs();
      repeat (25) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("[enveloped_led_overlay_blend] OK");
      end else begin
         $display("[enveloped_led_overlay_blend] ERROR");
      end
      $finish;
   end

endmodule
